[src/frfs_pkg.sv]
// Shared types and codes for the free region fit search block.
package frfs_pkg;

  // Field width of every address and length on the ports
  localparam int unsigned FIELD_BITS = 48;

  // Search mode codes
  localparam logic [2:0] MODE_FIRST     = 3'd0;
  localparam logic [2:0] MODE_LAST      = 3'd1;
  localparam logic [2:0] MODE_BEST_ANY  = 3'd2;
  localparam logic [2:0] MODE_BEST_FWD  = 3'd3;
  localparam logic [2:0] MODE_BEST_BWD  = 3'd4;
  localparam logic [2:0] MODE_LARGEST   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_SEARCH_MODE   = 3'd0;
  localparam logic [2:0] REG_MIN_LENGTH    = 3'd1;
  localparam logic [2:0] REG_PIVOT_CLUSTER = 3'd2;
  localparam logic [2:0] REG_WINDOW_FIRST  = 3'd3;
  localparam logic [2:0] REG_WINDOW_LAST   = 3'd4;

  // Input transaction: one free region
  typedef struct packed {
    logic [FIELD_BITS-1:0] region_start;
    logic [FIELD_BITS-1:0] region_length;
    logic                  last_region;
  } frfs_in_t;

  // Result transaction: chosen region and window count
  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] chosen_start;
    logic [FIELD_BITS-1:0] chosen_length;
    logic [FIELD_BITS-1:0] free_in_window;
  } frfs_out_t;

endpackage

[src/free_region_fit_search.sv]
// Free region fit search: region selection and windowed free cluster count.
//
// Usage:
//   Free regions arrive on the in_ channel (valid/ready), one per transaction,
//   in ascending address order; last_region marks the final region of a list.
//   Only that final region produces a result on the out_ channel: found flag,
//   the chosen region (zero when nothing matched) and the number of free
//   clusters inside [window_first, window_last).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) with
//   no wait; writes are made while no list result is outstanding.
// Timing:
//   One region per cycle sustained unless a final region must wait.
//   A region is captured in the input register; from there the compares,
//   one add and the saturating count update run against the running
//   search state, and a final region also loads the result register.
// Reset:
//   rst_n (synchronous, active low) empties both stages, clears the search
//   state and loads the register defaults (best fit any, minimum length 1).
// Stall:
//   While a result waits for out_ready, non-final regions keep flowing; a
//   final region waits in the input register, and in_ready drops only then.
module free_region_fit_search #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frfs_pkg::frfs_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frfs_pkg::frfs_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_wdata
);
  import frfs_pkg::*;

  // Effective address width: ports carry 48 bits
  localparam int unsigned AW = (ADDR_BITS < FIELD_BITS) ? ADDR_BITS : FIELD_BITS;

  // Configuration registers
  logic [2:0]    search_mode_r;
  logic [AW-1:0] min_length_r;
  logic [AW-1:0] pivot_cluster_r;
  logic [AW-1:0] window_first_r;
  logic [AW-1:0] window_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r   <= MODE_BEST_ANY;
      min_length_r    <= AW'(1);
      pivot_cluster_r <= '0;
      window_first_r  <= '0;
      window_last_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_MODE:   search_mode_r   <= cfg_wdata[2:0];
        REG_MIN_LENGTH:    min_length_r    <= cfg_wdata[AW-1:0];
        REG_PIVOT_CLUSTER: pivot_cluster_r <= cfg_wdata[AW-1:0];
        REG_WINDOW_FIRST:  window_first_r  <= cfg_wdata[AW-1:0];
        REG_WINDOW_LAST:   window_last_r   <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic          s1_valid_r;
  logic [AW-1:0] s1_start_r;
  logic [AW-1:0] s1_length_r;
  logic [AW:0]   s1_end_r;    // start + length with carry
  logic          s1_last_r;
  logic          s1_adv;
  logic          out_valid_r;
  frfs_out_t     out_data_r;

  // A final region needs the result register free or draining
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start_r  <= in_data.region_start[AW-1:0];
      s1_length_r <= in_data.region_length[AW-1:0];
      s1_end_r    <= {1'b0, in_data.region_start[AW-1:0]} +
                     {1'b0, in_data.region_length[AW-1:0]};
      s1_last_r   <= in_data.last_region;
    end
  end

  // Running search state
  logic          have_match_r,   have_match_nxt;
  logic          search_stopped_r, search_stopped_nxt;
  logic [AW-1:0] best_start_r,   best_start_nxt;
  logic [AW-1:0] best_length_r,  best_length_nxt;
  logic [AW-1:0] window_total_r, window_total_nxt;

  // Region search for the item in the input register
  logic          take;
  logic          stop;
  logic          len_ok;
  logic          best_better;

  always_comb begin
    len_ok      = (s1_length_r >= min_length_r);
    best_better = len_ok && (!have_match_r || (s1_length_r < best_length_r));
    take        = 1'b0;
    stop        = 1'b0;
    if (!search_stopped_r) begin
      case (search_mode_r)
        MODE_FIRST: begin
          take = len_ok;
          stop = len_ok;
        end
        MODE_LAST: begin
          take = len_ok;
        end
        MODE_BEST_ANY, MODE_BEST_FWD, MODE_BEST_BWD: begin
          if (search_mode_r == MODE_BEST_BWD && have_match_r &&
              s1_start_r > pivot_cluster_r) begin
            stop = 1'b1;
          end else begin
            take = best_better;
            stop = best_better && (s1_length_r == min_length_r) &&
                   (search_mode_r != MODE_BEST_FWD);
          end
        end
        MODE_LARGEST: begin
          take = (s1_length_r > best_length_r);
        end
        default: ;
      endcase
    end
  end

  // Window count for the item in the input register
  logic          beyond;
  logic [AW-1:0] reg_end;
  logic          counts;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] add;
  logic [AW:0]   total_sum;
  logic [AW-1:0] window_total_upd;

  always_comb begin
    beyond  = s1_end_r[AW];
    reg_end = s1_end_r[AW-1:0];
    counts  = (window_first_r < window_last_r) && (s1_start_r < window_last_r) &&
              (beyond || (reg_end > window_first_r));
    lo      = (s1_start_r > window_first_r) ? s1_start_r : window_first_r;
    hi      = (!beyond && (reg_end < window_last_r)) ? reg_end : window_last_r;
    add     = counts ? (hi - lo) : '0;
    total_sum = {1'b0, window_total_r} + {1'b0, add};
    // Saturate at all ones
    window_total_upd = total_sum[AW] ? '1 : total_sum[AW-1:0];
  end

  // Next state: updated by the region, cleared after a final region
  logic          found_w;
  logic [AW-1:0] chosen_start_w;
  logic [AW-1:0] chosen_length_w;

  always_comb begin
    found_w         = have_match_r || take;
    chosen_start_w  = take ? s1_start_r  : best_start_r;
    chosen_length_w = take ? s1_length_r : best_length_r;
    if (s1_last_r) begin
      have_match_nxt     = 1'b0;
      search_stopped_nxt = 1'b0;
      best_start_nxt     = '0;
      best_length_nxt    = '0;
      window_total_nxt   = '0;
    end else begin
      have_match_nxt     = found_w;
      search_stopped_nxt = search_stopped_r || stop;
      best_start_nxt     = chosen_start_w;
      best_length_nxt    = chosen_length_w;
      window_total_nxt   = window_total_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_match_r     <= 1'b0;
      search_stopped_r <= 1'b0;
      best_start_r     <= '0;
      best_length_r    <= '0;
      window_total_r   <= '0;
    end else if (s1_adv) begin
      have_match_r     <= have_match_nxt;
      search_stopped_r <= search_stopped_nxt;
      best_start_r     <= best_start_nxt;
      best_length_r    <= best_length_nxt;
      window_total_r   <= window_total_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r.found          <= found_w;
      out_data_r.chosen_start   <= found_w ? FIELD_BITS'(chosen_start_w)  : '0;
      out_data_r.chosen_length  <= found_w ? FIELD_BITS'(chosen_length_w) : '0;
      out_data_r.free_in_window <= FIELD_BITS'(window_total_upd);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_stop_implies_match: assert property (@(posedge clk) disable iff (!rst_n)
    search_stopped_r |-> have_match_r)
    else $error("search stopped without a held match");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (!have_match_r && !search_stopped_r &&
                               window_total_r == '0))
    else $error("search state not cleared after final region");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.chosen_start == '0 && out_data_r.chosen_length == '0))
    else $error("chosen region not zero when nothing found");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result raised without a final region");

endmodule
